// File: design/nsl_pkg.sv
// types, constants and saturating helpers shared by the slope limiter files
// no dependencies
`default_nettype none

package nsl_pkg;

	localparam int SAT_W   = 60;
	localparam int EPS_W   = 48;
	localparam int ORDER_W = 3;

	localparam logic [SAT_W-1:0]   SAT_MAX     = {SAT_W{1'b1}};
	localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd3;
	localparam logic [ORDER_W-1:0] ORDER_MAX   = 3'd5;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

	typedef enum logic [1:0] {
		ORD3 = 2'd0,
		ORD4 = 2'd1,
		ORD5 = 2'd2
	} ord_t;

	typedef struct packed {
		logic vld;
		logic early;
	} tag_t;

	function automatic logic [SAT_W-1:0] sat_add(input logic [SAT_W-1:0] x,
		input logic [SAT_W-1:0] y);
		logic [SAT_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[SAT_W] ? SAT_MAX : s[SAT_W-1:0];
	endfunction

	function automatic logic [SAT_W-1:0] sat_shl(input logic [SAT_W-1:0] x,
		input logic [1:0] k);
		logic [SAT_W+2:0] w;
		w = {3'b000, x} << k;
		return (w[SAT_W+2:SAT_W] != 3'b000) ? SAT_MAX : w[SAT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/nsl_if.sv
// face and result channel interfaces of the slope limiter
// depends on nsl_pkg
`default_nettype none

interface nsl_in_if
	import nsl_pkg::*;
#(
	parameter int DATA_WIDTH = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [DATA_WIDTH-1:0]  cell_value;
	logic signed [DATA_WIDTH-1:0]  stencil_min;
	logic signed [DATA_WIDTH-1:0]  stencil_max;
	logic signed [DATA_WIDTH-1:0]  face_delta;
	logic        [EPS_W-1:0]       smoothing_eps;

	modport source (output valid, cell_value, stencil_min, stencil_max, face_delta,
		smoothing_eps, input ready);
	modport sink (input valid, cell_value, stencil_min, stencil_max, face_delta,
		smoothing_eps, output ready);
endinterface

interface nsl_out_if #(
	parameter int FRAC_BITS = 16
) ();
	logic                   valid;
	logic                   ready;
	logic [FRAC_BITS+1:0]   limiter_value;
	logic                   early_unlimited;

	modport source (output valid, limiter_value, early_unlimited, input ready);
	modport sink (input valid, limiter_value, early_unlimited, output ready);
endinterface

`default_nettype wire

// File: design/nsl_mul.sv
// two-stage fixed point multiplier: (x*y) >> FRAC_BITS, saturating
// depends on nsl_pkg
`default_nettype none

module nsl_mul
	import nsl_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [SAT_W-1:0] x,
	input  wire logic [SAT_W-1:0] y,
	output logic      [SAT_W-1:0] p
);
	localparam int H  = SAT_W / 2;
	localparam int PW = 2 * SAT_W;

	logic [SAT_W-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0]    prod;
	logic [PW-1:0]    sh;

	// four 30x30 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= x[H-1:0] * y[H-1:0];
			lh_s1 <= x[H-1:0] * y[SAT_W-1:H];
			hl_s1 <= x[SAT_W-1:H] * y[H-1:0];
			hh_s1 <= x[SAT_W-1:H] * y[SAT_W-1:H];
		end
	end

	always_comb begin
		prod = {{SAT_W{1'b0}}, ll_s1}
			+ (({{SAT_W{1'b0}}, lh_s1} + {{SAT_W{1'b0}}, hl_s1}) << H)
			+ {hh_s1, {SAT_W{1'b0}}};
		sh = prod >> FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (sh[PW-1:SAT_W] != '0) ? SAT_MAX : sh[SAT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: design/nsl_div.sv
// pipelined restoring divider, one quotient bit per stage, with limiter saturation
// depends on nsl_pkg
`default_nettype none

module nsl_div
	import nsl_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [SAT_W-1:0]   num,
	input  wire logic [SAT_W-1:0]   den,
	input  wire tag_t               tag_i,
	output logic [FRAC_BITS+1:0]    q,
	output tag_t                    tag_o
);
	localparam int DS = FRAC_BITS + 2;
	localparam int LW = FRAC_BITS + 2;
	localparam int RW = SAT_W + 1;

	logic [RW-1:0]    r_s    [0:DS];
	logic [LW-1:0]    q_s    [0:DS];
	logic [SAT_W-1:0] den_s  [0:DS];
	logic             zero_s [0:DS];
	logic             big_s  [0:DS];
	tag_t             tag_s  [0:DS];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= {1'b0, num};
			q_s[0]    <= '0;
			den_s[0]  <= den;
			zero_s[0] <= (den == '0);
			big_s[0]  <= ({2'b00, num} >= {den, 2'b00});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DS; k++) tag_s[k] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_i;
			for (int k = 1; k <= DS; k++) tag_s[k] <= tag_s[k-1];
		end
	end

	for (genvar i = 0; i < DS; i++) begin : g_step
		logic [RW-1:0] rr;
		logic [RW-1:0] trial;
		logic          ge;

		// two integer steps on the raw remainder, then one per fraction bit
		always_comb begin
			rr    = (i < 2) ? r_s[i] : {r_s[i][RW-2:0], 1'b0};
			trial = (i == 0) ? {den_s[i], 1'b0} : {1'b0, den_s[i]};
			ge    = (rr >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1]    <= ge ? (rr - trial) : rr;
				q_s[i+1]    <= {q_s[i][LW-2:0], ge};
				den_s[i+1]  <= den_s[i];
				zero_s[i+1] <= zero_s[i];
				big_s[i+1]  <= big_s[i];
			end
		end
	end

	always_comb begin
		priority if (zero_s[DS]) q = '0;
		else if (big_s[DS])      q = {LW{1'b1}};
		else                     q = q_s[DS];
	end

	assign tag_o = tag_s[DS];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s[DS].vld && !zero_s[DS] && !big_s[DS] |-> r_s[DS] < {1'b0, den_s[DS]})
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

// File: design/nishikawa_slope_limiter.sv
// rational slope limiter of order 3 to 5, one face beat per cycle while the result is not stalled
// pipeline: 13 arithmetic stages built around the multipliers,
// FRAC_BITS+3 divider stages (an input register, then one quotient bit each), one output register
// throughput one beat per cycle; a stalled result freezes the whole pipe in place
// reset clears all valid bits and sets the order register to 3
// depends on nsl_pkg, nsl_if, nsl_mul, nsl_div
`default_nettype none

module nishikawa_slope_limiter
	import nsl_pkg::*;
#(
	parameter int DATA_WIDTH = 24,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [ORDER_W-1:0] cfg_wr_data,
	nsl_in_if.sink                  face,
	nsl_out_if.source               result
);
	localparam int DW = DATA_WIDTH;
	localparam int AW = DATA_WIDTH + 1;
	localparam int LW = FRAC_BITS + 2;
	localparam logic [LW-1:0] ONE_FX = LW'(1) << FRAC_BITS;

	function automatic logic [SAT_W-1:0] zx(input logic [AW-1:0] v);
		return {{(SAT_W-AW){1'b0}}, v};
	endfunction

	logic               en;
	logic [ORDER_W-1:0] order_q;
	ord_t               ord_c;

	logic signed [DW:0] delp;
	logic signed [DW:0] diff_x;
	logic [AW-1:0]      a_c, b_c, d_c, absd;
	logic               early_c;

	logic             vld_s   [1:13];
	logic             early_s [1:13];
	ord_t             ord_s   [1:9];
	logic [AW-1:0]    a_s     [1:10];
	logic [AW-1:0]    b_s     [1:10];
	logic [AW-1:0]    d_s1;
	logic [EPS_W-1:0] eps_s   [1:9];

	logic [SAT_W-1:0] a2_s3, d2_s3, b2_s3, a3_s5, a4_s7, a5_s9;
	logic [SAT_W-1:0] bi_s6, b2i_s6, as_s12, bt_s12;
	logic [SAT_W-1:0] a2_s   [4:9];
	logic [SAT_W-1:0] a3_s   [6:9];
	logic [SAT_W-1:0] a4_s   [8:9];
	logic [SAT_W-1:0] b2_s   [4:6];
	logic [SAT_W-1:0] inner_s4;
	logic [SAT_W-1:0] sp_s   [7:10];
	logic [SAT_W-1:0] fun1_s [10:12];
	logic [SAT_W-1:0] t_s10;
	logic [SAT_W-1:0] num_s13, den_s13;
	logic [SAT_W-1:0] powp_c, powm1_c, sp_c;

	tag_t          tag_in, tag_out;
	logic [LW-1:0] q_div;

	logic          res_vld_q;
	logic [LW-1:0] lim_q;
	logic          early_q;

	assign en         = !res_vld_q || result.ready;
	assign face.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	always_comb begin
		priority if (order_q < ORDER_MIN) ord_c = ORD3;
		else if (order_q >= ORDER_MAX)    ord_c = ORD5;
		else if (order_q == ORDER_MIN)    ord_c = ORD3;
		else                              ord_c = ORD4;
	end

	// zero difference takes the max side
	always_comb begin
		diff_x  = {face.face_delta[DW-1], face.face_delta};
		delp    = face.face_delta[DW-1]
			? ({face.stencil_min[DW-1], face.stencil_min} - {face.cell_value[DW-1], face.cell_value})
			: ({face.stencil_max[DW-1], face.stencil_max} - {face.cell_value[DW-1], face.cell_value});
		a_c     = delp[DW] ? AW'(-delp) : AW'(delp);
		absd    = diff_x[DW] ? AW'(-diff_x) : AW'(diff_x);
		b_c     = absd + AW'(1);
		early_c = ({1'b0, a_c} > {b_c, 1'b0});
		d_c     = (a_c >= b_c) ? (a_c - b_c) : (b_c - a_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 13; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= face.valid;
			for (int k = 2; k <= 13; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			early_s[1] <= early_c;
			ord_s[1]   <= ord_c;
			a_s[1]     <= a_c;
			b_s[1]     <= b_c;
			d_s1       <= d_c;
			eps_s[1]   <= face.smoothing_eps;
			for (int k = 2; k <= 13; k++) early_s[k] <= early_s[k-1];
			for (int k = 2; k <= 9; k++)  ord_s[k]   <= ord_s[k-1];
			for (int k = 2; k <= 10; k++) a_s[k]     <= a_s[k-1];
			for (int k = 2; k <= 10; k++) b_s[k]     <= b_s[k-1];
			for (int k = 2; k <= 9; k++)  eps_s[k]   <= eps_s[k-1];

			a2_s[4] <= a2_s3;
			for (int k = 5; k <= 9; k++) a2_s[k] <= a2_s[k-1];
			a3_s[6] <= a3_s5;
			for (int k = 7; k <= 9; k++) a3_s[k] <= a3_s[k-1];
			a4_s[8] <= a4_s7;
			a4_s[9] <= a4_s[8];
			b2_s[4] <= b2_s3;
			b2_s[5] <= b2_s[4];
			b2_s[6] <= b2_s[5];

			// (a-b)^2 + b^2 stands in for a^2 - 2b(a-b)
			inner_s4 <= sat_add(d2_s3, b2_s3);

			sp_s[7] <= sp_c;
			for (int k = 8; k <= 10; k++) sp_s[k] <= sp_s[k-1];

			fun1_s[10] <= sat_add(powp_c, {{(SAT_W-EPS_W){1'b0}}, eps_s[9]});
			t_s10      <= sat_add(powm1_c, sp_s[9]);
			fun1_s[11] <= fun1_s[10];
			fun1_s[12] <= fun1_s[11];

			num_s13 <= sat_add(fun1_s[12], as_s12);
			den_s13 <= sat_add(fun1_s[12], bt_s12);
		end
	end

	always_comb begin
		unique case (ord_s[6])
			ORD3:    sp_c = sat_shl(b2_s[6], 2'd2);
			ORD4:    sp_c = sat_shl(bi_s6, 2'd1);
			ORD5:    sp_c = sat_shl(b2i_s6, 2'd3);
			default: sp_c = sat_shl(b2_s[6], 2'd2);
		endcase
	end

	always_comb begin
		unique case (ord_s[9])
			ORD3: begin
				powp_c  = a3_s[9];
				powm1_c = a2_s[9];
			end
			ORD4: begin
				powp_c  = a4_s[9];
				powm1_c = a3_s[9];
			end
			ORD5: begin
				powp_c  = a5_s9;
				powm1_c = a4_s[9];
			end
			default: begin
				powp_c  = a3_s[9];
				powm1_c = a2_s[9];
			end
		endcase
	end

	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_aa (.clk(clk), .en(en),
		.x(zx(a_s[1])), .y(zx(a_s[1])), .p(a2_s3));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_dd (.clk(clk), .en(en),
		.x(zx(d_s1)), .y(zx(d_s1)), .p(d2_s3));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bb (.clk(clk), .en(en),
		.x(zx(b_s[1])), .y(zx(b_s[1])), .p(b2_s3));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a3 (.clk(clk), .en(en),
		.x(a2_s3), .y(zx(a_s[3])), .p(a3_s5));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bi (.clk(clk), .en(en),
		.x(zx(b_s[4])), .y(inner_s4), .p(bi_s6));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b2i (.clk(clk), .en(en),
		.x(b2_s[4]), .y(inner_s4), .p(b2i_s6));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a4 (.clk(clk), .en(en),
		.x(a3_s5), .y(zx(a_s[5])), .p(a4_s7));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a5 (.clk(clk), .en(en),
		.x(a4_s7), .y(zx(a_s[7])), .p(a5_s9));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_as (.clk(clk), .en(en),
		.x(zx(a_s[10])), .y(sp_s[10]), .p(as_s12));
	nsl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_bt (.clk(clk), .en(en),
		.x(zx(b_s[10])), .y(t_s10), .p(bt_s12));

	assign tag_in.vld   = vld_s[13];
	assign tag_in.early = early_s[13];

	nsl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.num    (num_s13),
		.den    (den_s13),
		.tag_i  (tag_in),
		.q      (q_div),
		.tag_o  (tag_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= tag_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lim_q   <= tag_out.early ? ONE_FX : q_div;
			early_q <= tag_out.early;
		end
	end

	assign result.valid           = res_vld_q;
	assign result.limiter_value   = lim_q;
	assign result.early_unlimited = early_q;

	a_early_is_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && early_q |-> lim_q == ONE_FX)
		else $error("shortcut beat without unit factor");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[13] && !en |=> vld_s[13] && tag_in.vld)
		else $error("stage dropped during stall");

	a_early_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] && early_s[1] |-> a_s[1] != '0)
		else $error("shortcut with zero allowed change");

endmodule

`default_nettype wire
